FILE: hdl/cdq_pkg.sv
// shared definitions for the circular deque with search
// command and status codes, default depth, controller/datapath interface structs
// no dependencies
package cdq_pkg;

	localparam int DEPTH_DEF = 16;

	localparam logic [2:0] CMD_INS_FRONT = 3'd0;
	localparam logic [2:0] CMD_INS_BACK  = 3'd1;
	localparam logic [2:0] CMD_REM_FRONT = 3'd2;
	localparam logic [2:0] CMD_REM_BACK  = 3'd3;
	localparam logic [2:0] CMD_SEARCH    = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic load;    // capture a new command word
		logic exec;    // apply an insert, removal or ignored command
		logic scan;    // search step
		logic finish;  // search ends this cycle
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic is_search;
		logic scan_end;
	} sts_t;

endpackage

FILE: hdl/circular_deque_with_search_core.sv
// Bounded double-ended queue of signed 32-bit words held in a ring buffer with
// search. A command word (cmd, value) is taken when start is high and busy is
// low; exactly one result (status, found, count, is_empty) follows, shown for one
// cycle with done high, and the receiver must take it then. Inserts, removals
// and unused codes go from the execute state straight back to idle; the result
// appears in the cycle in which busy drops, and the next command may be taken
// at the same edge that takes the result. A search reads the stored entries front
// to back through the single read port of the entry memory, one entry per cycle,
// and stops early when it hits. Entry memory needs no clearing after reset.
// depends on cdq_pkg, cdq_ctrl and cdq_datapath
module circular_deque_with_search_core #(
	parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic        [2:0]  cmd,
	input  logic signed [31:0] value,
	output logic               done,
	output logic        [1:0]  status,
	output logic               found,
	output logic        [4:0]  count,
	output logic               is_empty
);
	import cdq_pkg::*;

	ctl_t ctl;
	sts_t sts;

	cdq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy)
	);

	cdq_datapath #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_in   (cmd),
		.value_in (value),
		.ctl      (ctl),
		.sts      (sts),
		.status   (status),
		.found    (found),
		.count    (count),
		.is_empty (is_empty),
		.done     (done)
	);

`ifndef SYNTHESIS
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a command in progress");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted command did not raise busy");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_EMPTY) |-> is_empty)
		else $error("empty status on a non-empty store");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && found) |-> (status == ST_OK && !is_empty))
		else $error("found flag with bad status or empty store");
`endif

endmodule

FILE: hdl/cdq_ctrl.sv
// controller state machine for the circular deque with search
// depends on cdq_pkg for the controller and datapath structs
module cdq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  cdq_pkg::sts_t sts,
	output cdq_pkg::ctl_t ctl,
	output logic          busy
);
	import cdq_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_EXEC   = 2'd1;
	localparam logic [1:0] S_SEARCH = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) state_nxt = S_EXEC;
			end
			S_EXEC: begin
				state_nxt = sts.is_search ? S_SEARCH : S_IDLE;
			end
			S_SEARCH: begin
				if (sts.scan_end) state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign ctl.load   = start && (state_q == S_IDLE);
	assign ctl.exec   = (state_q == S_EXEC) && !sts.is_search;
	assign ctl.scan   = (state_q == S_SEARCH);
	assign ctl.finish = (state_q == S_SEARCH) && sts.scan_end;

endmodule

FILE: hdl/cdq_datapath.sv
// datapath for the circular deque with search: entry memory, ring pointers,
// count, search scan pipeline and result registers
// depends on cdq_pkg for codes and the controller structs
module cdq_datapath #(
	parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic        [2:0]  cmd_in,
	input  logic signed [31:0] value_in,
	input  cdq_pkg::ctl_t      ctl,
	output cdq_pkg::sts_t      sts,
	output logic        [1:0]  status,
	output logic               found,
	output logic        [4:0]  count,
	output logic               is_empty,
	output logic               done
);
	import cdq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
	localparam logic [CW:0]   RING_LEN = (CW + 1)'(DEPTH);

	logic signed [31:0] mem [DEPTH];

	logic        [2:0]  cmd_q;
	logic signed [31:0] value_q;
	logic      [AW-1:0] front_q;
	logic      [CW-1:0] cnt_q;
	logic      [AW-1:0] scan_ptr_q;
	logic      [CW-1:0] scan_cnt_q;
	logic               rd_vld_s1;
	logic signed [31:0] rdata_s1;

	logic      [1:0]    status_q;
	logic               found_q;
	logic      [4:0]    count_q;
	logic               is_empty_q;
	logic               done_q;

	logic      [AW-1:0] front_dec;
	logic      [AW-1:0] front_inc;
	logic      [AW-1:0] scan_inc;
	logic      [CW:0]   back_sum;
	logic      [CW:0]   back_pos;
	logic      [AW-1:0] wr_addr;
	logic               wr_en;
	logic               rd_en;
	logic               hit;
	logic      [AW-1:0] front_nxt;
	logic      [CW-1:0] cnt_nxt;
	logic      [1:0]    st_nxt;
	logic      [CW+4:0] cnt_ext;

	assign front_dec = (front_q == '0) ? LAST_IDX : front_q - AW'(1);
	assign front_inc = (front_q == LAST_IDX) ? '0 : front_q + AW'(1);
	assign scan_inc  = (scan_ptr_q == LAST_IDX) ? '0 : scan_ptr_q + AW'(1);
	// front + count stays below twice the depth, one subtract wraps it
	assign back_sum  = (CW + 1)'(front_q) + (CW + 1)'(cnt_q);
	assign back_pos  = (back_sum >= RING_LEN) ? back_sum - RING_LEN : back_sum;

	always_comb begin
		wr_en     = 1'b0;
		wr_addr   = front_dec;
		front_nxt = front_q;
		cnt_nxt   = cnt_q;
		st_nxt    = ST_OK;
		unique case (cmd_q)
			CMD_INS_FRONT: begin
				if (cnt_q >= FULL_CNT) begin
					st_nxt = ST_FULL;
				end else begin
					wr_en     = ctl.exec;
					front_nxt = front_dec;
					cnt_nxt   = cnt_q + CW'(1);
				end
			end
			CMD_INS_BACK: begin
				wr_addr = back_pos[AW-1:0];
				if (cnt_q >= FULL_CNT) begin
					st_nxt = ST_FULL;
				end else begin
					wr_en   = ctl.exec;
					cnt_nxt = cnt_q + CW'(1);
				end
			end
			CMD_REM_FRONT: begin
				if (cnt_q == '0) begin
					st_nxt = ST_EMPTY;
				end else begin
					front_nxt = front_inc;
					cnt_nxt   = cnt_q - CW'(1);
				end
			end
			CMD_REM_BACK: begin
				if (cnt_q == '0) begin
					st_nxt = ST_EMPTY;
				end else begin
					cnt_nxt = cnt_q - CW'(1);
				end
			end
			default: begin
				// search and unused codes leave the store alone
			end
		endcase
	end

	// scan issues one read a cycle, compare follows in the next cycle
	assign rd_en = ctl.scan && (scan_cnt_q != cnt_q);
	assign hit   = rd_vld_s1 && (rdata_s1 == value_q);

	assign sts.is_search = (cmd_q == CMD_SEARCH);
	assign sts.scan_end  = hit || ((scan_cnt_q == cnt_q) && !rd_vld_s1);

	assign cnt_ext = {5'b0, cnt_nxt};

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= value_q;
		if (rd_en) rdata_s1 <= mem[scan_ptr_q];
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q   <= cmd_in;
			value_q <= value_in;
		end
		if (ctl.exec || ctl.finish) begin
			status_q   <= ctl.exec ? st_nxt : ST_OK;
			found_q    <= ctl.finish && hit;
			count_q    <= cnt_ext[4:0];
			is_empty_q <= (cnt_nxt == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q    <= '0;
			cnt_q      <= '0;
			scan_ptr_q <= '0;
			scan_cnt_q <= '0;
			rd_vld_s1  <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			done_q    <= ctl.exec || ctl.finish;
			if (ctl.exec) begin
				front_q <= front_nxt;
				cnt_q   <= cnt_nxt;
			end
			if (ctl.load) begin
				scan_ptr_q <= front_q;
				scan_cnt_q <= '0;
			end else if (rd_en) begin
				scan_ptr_q <= scan_inc;
				scan_cnt_q <= scan_cnt_q + CW'(1);
			end
		end
	end

	assign status   = status_q;
	assign found    = found_q;
	assign count    = count_q;
	assign is_empty = is_empty_q;
	assign done     = done_q;

endmodule
